// File: src/circular_fifo_queue_assert.svh
// assertion macros for the queue checker
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define CFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cfq_pkg.sv
// shared types and constants for the circular fifo queue
package cfq_pkg;

  localparam int DataW      = 32;
  localparam int CountW     = 5;
  localparam int FuncW      = 2;
  localparam int StatusW    = 2;
  localparam int DepthDflt  = 16;
  localparam int CapResetRaw = 16;

  typedef enum logic [FuncW-1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_OVER  = 2'd1,
    STATUS_UNDER = 2'd2
  } status_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                     shift;
    logic                     enq;
    logic [CountW-1:0]        count;
    logic signed [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

// File: src/cfq_cell.sv
// one storage cell of the shifting queue chain
module cfq_cell #(
  parameter int Idx = 0
) (
  input  logic                               clk,
  input  cfq_pkg::cell_ctrl_t                ctrl,
  input  logic signed [cfq_pkg::DataW-1:0]   right_data,
  output logic signed [cfq_pkg::DataW-1:0]   cell_data
);

  // cells beyond the largest count can never be the tail
  localparam bit Reachable = Idx < ((2 ** cfq_pkg::CountW) - 1);
  localparam logic [cfq_pkg::CountW-1:0] IdxW = cfq_pkg::CountW'(Idx);

  logic load;

  assign load = Reachable && ctrl.enq && (ctrl.count == IdxW);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_data <= right_data;
    end else if (load) begin
      cell_data <= ctrl.value;
    end
  end

endmodule

// File: src/circular_fifo_queue.sv
// top level of the circular fifo queue built as a shifting cell chain
//
// command port: an operation is taken on a clock edge with start high and busy
// low; func picks enqueue, dequeue, peek or clear, value carries the word to
// enqueue. busy never rises, so a new beat can be issued in every cycle.
// every beat gives exactly one result beat: done is high for one cycle, in the
// cycle after the accepting edge, with data, status, count, empty_res and
// full_res valid in that cycle. the receiver cannot stall; it must sample then.
// storage is a row of DEPTH cells: the head sits in cell 0, an enqueue lands in
// the cell indexed by the entry count, a dequeue shifts every cell one step
// toward the head in the same cycle. the cell update plus the count increment
// and compare all complete at the accepting edge and set the one-beat-per-cycle
// throughput.
// capacity is written through cfg_we / cfg_data; zero acts as one and values
// above DEPTH act as DEPTH. a write empties the queue.
// reset (synchronous, active high) empties the queue, sets capacity to 16
// (clamped to DEPTH) and drops done; cell contents are not cleared.
module circular_fifo_queue #(
  parameter int DEPTH = cfq_pkg::DepthDflt
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [cfq_pkg::FuncW-1:0]             func,
  input  logic signed [cfq_pkg::DataW-1:0]      value,
  input  logic                                  cfg_we,
  input  logic [cfq_pkg::CountW-1:0]            cfg_data,
  output logic                                  done,
  output logic signed [cfq_pkg::DataW-1:0]      data,
  output logic [cfq_pkg::StatusW-1:0]           status,
  output logic [cfq_pkg::CountW-1:0]            count,
  output logic                                  empty_res,
  output logic                                  full_res
);

  localparam int CountW   = cfq_pkg::CountW;
  localparam int DataW    = cfq_pkg::DataW;
  // largest usable capacity: the store depth or the register range
  localparam int CapLimit = (DEPTH < ((2 ** CountW) - 1)) ? DEPTH : ((2 ** CountW) - 1);
  localparam logic [CountW-1:0] CapLimitW = CountW'(CapLimit);
  localparam logic [CountW-1:0] CapResetW =
    (cfq_pkg::CapResetRaw > CapLimit) ? CapLimitW : CountW'(cfq_pkg::CapResetRaw);
  localparam logic [CountW-1:0] CountOne  = CountW'(1);

  // control state
  logic [CountW-1:0] entry_count;
  logic [CountW-1:0] entry_count_next;
  logic [CountW-1:0] cap_eff;
  logic [CountW-1:0] cap_wr;

  // result beat
  logic signed [DataW-1:0]        data_next;
  logic [cfq_pkg::StatusW-1:0]    status_next;

  logic is_full;
  logic is_empty;
  logic accept;

  cfq_pkg::cell_ctrl_t ctrl;

  logic signed [DataW-1:0] cell_data [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (entry_count == cap_eff);
  assign is_empty = (entry_count == '0);

  // clamp a written capacity into one .. CapLimit
  always_comb begin
    if (cfg_data == '0) begin
      cap_wr = CountOne;
    end else if (cfg_data > CapLimitW) begin
      cap_wr = CapLimitW;
    end else begin
      cap_wr = cfg_data;
    end
  end

  // operation decode
  always_comb begin
    entry_count_next = entry_count;
    data_next        = '0;
    status_next      = cfq_pkg::STATUS_OK;
    ctrl.shift       = 1'b0;
    ctrl.enq         = 1'b0;
    ctrl.count       = entry_count;
    ctrl.value       = value;
    if (accept) begin
      unique case (cfq_pkg::func_t'(func))
        cfq_pkg::FUNC_ENQ: begin
          if (is_full) begin
            status_next = cfq_pkg::STATUS_OVER;
          end else begin
            ctrl.enq         = 1'b1;
            entry_count_next = entry_count + CountOne;
          end
        end
        cfq_pkg::FUNC_DEQ: begin
          if (is_empty) begin
            status_next = cfq_pkg::STATUS_UNDER;
          end else begin
            data_next        = cell_data[0];
            ctrl.shift       = 1'b1;
            entry_count_next = entry_count - CountOne;
          end
        end
        cfq_pkg::FUNC_PEEK: begin
          if (is_empty) begin
            status_next = cfq_pkg::STATUS_UNDER;
          end else begin
            data_next = cell_data[0];
          end
        end
        cfq_pkg::FUNC_CLEAR: begin
          entry_count_next = '0;
        end
      endcase
    end
  end

  // cell chain: each cell takes its right neighbor on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] right_data;
    if (i == DEPTH - 1) begin : g_tail
      assign right_data = '0;
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end
    cfq_cell #(
      .Idx (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .right_data (right_data),
      .cell_data  (cell_data[i])
    );
  end

  // count, capacity and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cap_eff     <= CapResetW;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_we) begin
        // a capacity write empties the queue
        cap_eff     <= cap_wr;
        entry_count <= '0;
      end else begin
        entry_count <= entry_count_next;
      end
    end
  end

  // result payload, valid while done is high
  always_ff @(posedge clk) begin
    data      <= data_next;
    status    <= status_next;
    count     <= entry_count_next;
    empty_res <= (entry_count_next == '0);
    full_res  <= (entry_count_next == cap_eff);
  end

endmodule

// File: src/cfq_checker.sv
// port-level checker for the circular fifo queue, bound to the top level
`include "circular_fifo_queue_assert.svh"

module cfq_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic [cfq_pkg::FuncW-1:0]             func,
  input logic signed [cfq_pkg::DataW-1:0]      value,
  input logic                                  cfg_we,
  input logic [cfq_pkg::CountW-1:0]            cfg_data,
  input logic                                  done,
  input logic signed [cfq_pkg::DataW-1:0]      data,
  input logic [cfq_pkg::StatusW-1:0]           status,
  input logic [cfq_pkg::CountW-1:0]            count,
  input logic                                  empty_res,
  input logic                                  full_res
);

  logic accept;
  logic unused_ok;

  assign accept    = start && !busy;
  assign unused_ok = ^{func, value, cfg_we, cfg_data};

  // every accepted beat yields one result beat in the next cycle
  `CFQ_ASSERT_NEXT(a_done_follows, accept, done, "result beat missing after accept")
  // no result beat without a command beat
  `CFQ_ASSERT_NEXT(a_no_spurious, !accept, !done, "result beat without a command")
  // empty flag agrees with the reported count
  `CFQ_ASSERT_NOW(a_empty_count, done, empty_res == (count == '0), "empty flag mismatch")
  // overflow only when the queue is full and not empty
  `CFQ_ASSERT_NOW(a_over_full, done && (status == cfq_pkg::STATUS_OVER),
                  full_res && !empty_res, "overflow while not full")
  // underflow leaves an empty queue and zero data
  `CFQ_ASSERT_NOW(a_under_empty, done && (status == cfq_pkg::STATUS_UNDER),
                  empty_res && (data == '0), "underflow with data or entries")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);

// File: test/tb_circular_fifo_queue.sv
`timescale 1ns / 1ps
// self-checking testbench for the circular fifo queue: directed corner cases, then random traffic
module tb_circular_fifo_queue;

  localparam int DataW      = cfq_pkg::DataW;
  localparam int CountW     = cfq_pkg::CountW;
  localparam int FuncW      = cfq_pkg::FuncW;
  localparam int StatusW    = cfq_pkg::StatusW;
  localparam int Depth      = cfq_pkg::DepthDflt;
  localparam int PtrW       = $clog2(Depth);
  localparam int CycleLimit = 200000;
  localparam int ResetCycles = 12;

  // extreme words for the directed beats
  localparam logic signed [DataW-1:0] WordMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] WordMax = ~WordMin;

  // what one result beat should carry
  typedef struct {
    logic signed [DataW-1:0] data;
    cfq_pkg::status_t        status;
    logic [CountW-1:0]       count;
    logic                    empty_res;
    logic                    full_res;
  } fifo_result_t;

  // block ports, every input known from time zero
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic                     busy;
  logic [FuncW-1:0]         func      = cfq_pkg::FUNC_ENQ;
  logic signed [DataW-1:0]  value     = '0;
  logic                     cfg_we    = 1'b0;
  logic [CountW-1:0]        cfg_data  = '0;
  logic                     done;
  logic signed [DataW-1:0]  data;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        count;
  logic                     empty_res;
  logic                     full_res;

  // mirror of the queue: ring store, pointers, entry count, raw capacity register
  logic signed [DataW-1:0]  ring_mem [Depth];
  int unsigned              rd_ptr   = 0;
  int unsigned              wr_ptr   = 0;
  int unsigned              held     = 0;
  int unsigned              cap_raw  = cfq_pkg::CapResetRaw;

  // results still owed by the block, oldest first
  fifo_result_t             pending_results [$];

  int unsigned              mismatch_count = 0;
  int unsigned              cycle_count    = 0;

  // capacity walk for the random segments: extremes first, then fixed mid values, then random values
  logic [CountW-1:0]        cap_plan [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd9};
  int unsigned              plan_idx = 0;

  circular_fifo_queue #(
    .DEPTH(Depth)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .done      (done),
    .data      (data),
    .status    (status),
    .count     (count),
    .empty_res (empty_res),
    .full_res  (full_res)
  );

  always #2 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // queue prediction
  // ---------------------------------------------------------------------------

  // register value clamped into 1..Depth
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = cap_raw;
    if (c < 1) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  // pointer step with wrap at the usable capacity
  function automatic int unsigned next_slot(int unsigned p, int unsigned cap);
    int unsigned n;
    n = p + 1;
    if (n >= cap) n = 0;
    return n;
  endfunction

  function automatic void empty_mirror();
    rd_ptr = 0;
    wr_ptr = 0;
    held   = 0;
  endfunction

  // apply one accepted operation to the mirror and queue the result it owes
  function automatic void predict_fifo_op(cfq_pkg::func_t op, logic signed [DataW-1:0] word);
    int unsigned  cap;
    fifo_result_t r;
    cap      = usable_slots();
    r.data   = '0;
    r.status = cfq_pkg::STATUS_OK;
    // pointers beyond the capacity cannot survive; treat as an empty queue
    if (held > cap || rd_ptr >= cap || wr_ptr >= cap) empty_mirror();
    case (op)
      cfq_pkg::FUNC_ENQ: begin
        if (held >= cap) begin
          r.status = cfq_pkg::STATUS_OVER;
        end else begin
          ring_mem[PtrW'(wr_ptr)] = word;
          wr_ptr = next_slot(wr_ptr, cap);
          held++;
        end
      end
      cfq_pkg::FUNC_DEQ, cfq_pkg::FUNC_PEEK: begin
        if (held == 0) begin
          r.status = cfq_pkg::STATUS_UNDER;
        end else begin
          r.data = ring_mem[PtrW'(rd_ptr)];
          if (op == cfq_pkg::FUNC_DEQ) begin
            rd_ptr = next_slot(rd_ptr, cap);
            held--;
          end
        end
      end
      default: begin
        // clear keeps the store, drops pointers and count
        empty_mirror();
      end
    endcase
    r.count     = CountW'(held);
    r.empty_res = (held == 0);
    r.full_res  = (held == cap);
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, sampled at the rising edge before the block updates
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [DataW-1:0] expv,
                                      logic [DataW-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data", want.data, data);
        check_field("status", DataW'(want.status), DataW'(status));
        check_field("count", DataW'(want.count), DataW'(count));
        check_field("empty_res", DataW'(want.empty_res), DataW'(empty_res));
        check_field("full_res", DataW'(want.full_res), DataW'(full_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers: inputs move on the falling edge
  // ---------------------------------------------------------------------------

  // issue one command beat and hold it until the block takes it
  task automatic send_op(cfq_pkg::func_t op, logic signed [DataW-1:0] word);
    @(negedge clk);
    start <= 1'b1;
    func  <= op;
    value <= word;
    do @(posedge clk); while (busy);
    predict_fifo_op(op, word);
  endtask

  // random gap between beats; start drops only when a gap is taken
  task automatic sender_pause(int unsigned pct);
    int unsigned gap;
    if ($urandom_range(0, 99) < pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop issuing and let every owed result come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // capacity write, only with the queue quiet; it also empties the queue
  task automatic set_capacity(logic [CountW-1:0] c);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cap_raw = 32'(c);
    empty_mirror();
  endtask

  // mostly full-range words, sometimes the extremes
  function automatic logic signed [DataW-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return WordMin;
      1:       return WordMax;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CountW-1:0] next_capacity();
    logic [CountW-1:0] c;
    c = (plan_idx < 8) ? cap_plan[plan_idx] : CountW'($urandom_range(0, 31));
    plan_idx++;
    return c;
  endfunction

  // random traffic in four capacity segments; bursts lean toward filling,
  // draining or balance so the queue hits full, empty and wraps often
  task automatic run_random_phase(int unsigned pct, int unsigned items);
    int unsigned    seg;
    int unsigned    sent;
    int unsigned    lean;
    int unsigned    pick;
    cfq_pkg::func_t op;
    for (seg = 0; seg < 4; seg++) begin
      set_capacity(next_capacity());
      sent = 0;
      while (sent < items / 4) begin
        lean = $urandom_range(0, 2);
        repeat ($urandom_range(8, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 3)         op = cfq_pkg::FUNC_CLEAR;
          else if (pick < 15)   op = cfq_pkg::FUNC_PEEK;
          else if (lean == 0)   op = (pick < 75) ? cfq_pkg::FUNC_ENQ : cfq_pkg::FUNC_DEQ;
          else if (lean == 1)   op = (pick < 40) ? cfq_pkg::FUNC_ENQ : cfq_pkg::FUNC_DEQ;
          else                  op = (pick < 57) ? cfq_pkg::FUNC_ENQ : cfq_pkg::FUNC_DEQ;
          send_op(op, random_word());
          sender_pause(pct);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reads from the queue right after reset underflow
  task automatic test_empty_queue();
    send_op(cfq_pkg::FUNC_DEQ, WordMax);
    send_op(cfq_pkg::FUNC_PEEK, WordMin);
  endtask

  // one-slot queue, then a zero register that must act as one slot
  task automatic test_single_slot();
    set_capacity(5'd1);
    send_op(cfq_pkg::FUNC_ENQ, WordMax);
    send_op(cfq_pkg::FUNC_ENQ, WordMin);
    send_op(cfq_pkg::FUNC_PEEK, '0);
    send_op(cfq_pkg::FUNC_DEQ, '0);
    send_op(cfq_pkg::FUNC_DEQ, '0);
    set_capacity(5'd0);
    send_op(cfq_pkg::FUNC_ENQ, '1);
    send_op(cfq_pkg::FUNC_ENQ, '0);
    send_op(cfq_pkg::FUNC_CLEAR, '0);
  endtask

  // small queue: overflow, pointer wrap, clear, then underflow
  task automatic test_wraparound();
    set_capacity(5'd3);
    send_op(cfq_pkg::FUNC_ENQ, WordMin);
    send_op(cfq_pkg::FUNC_ENQ, WordMax);
    send_op(cfq_pkg::FUNC_ENQ, '1);
    send_op(cfq_pkg::FUNC_ENQ, 32'sh5555_5555);
    send_op(cfq_pkg::FUNC_DEQ, '0);
    send_op(cfq_pkg::FUNC_ENQ, 32'shAAAA_AAAA);
    send_op(cfq_pkg::FUNC_PEEK, '0);
    send_op(cfq_pkg::FUNC_CLEAR, '1);
    send_op(cfq_pkg::FUNC_PEEK, '0);
  endtask

  // register above the store size clamps to the full store
  task automatic test_oversized_capacity();
    set_capacity(5'd17);
    send_op(cfq_pkg::FUNC_ENQ, 32'sh1234_5678);
    send_op(cfq_pkg::FUNC_DEQ, '0);
  endtask

  task automatic test_back_to_back();
    run_random_phase(0, 600);
  endtask

  task automatic test_sparse_sender();
    run_random_phase(72, 600);
  endtask

  task automatic test_light_sender();
    run_random_phase(17, 600);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_single_slot();
    test_wraparound();
    test_oversized_capacity();
    test_back_to_back();
    test_sparse_sender();
    test_light_sender();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: circular_fifo_queue.f
+incdir+src
src/cfq_pkg.sv
src/cfq_cell.sv
src/circular_fifo_queue.sv
src/cfq_checker.sv
test/tb_circular_fifo_queue.sv
